// File: hw/rtl/ifr_pkg.sv
package ifr_pkg;

  // Field widths of the two channels and of the configuration register.
  localparam int HandleBits = 32;
  localparam int TimeBits   = 63;
  localparam int PtsBits    = 64;
  localparam int TbBits     = 31;
  localparam int PeriodBits = 30;

  // Rescale arithmetic: divisor is 1e9 * numerator, dividend is time * den + half.
  localparam int DivBits  = 61;
  localparam int AccBits  = 95;
  localparam int QuotBits = 63;
  localparam int CntBits  = 6;

  localparam logic [PeriodBits-1:0] NsPerS      = 30'd1000000000;
  localparam logic [PeriodBits-1:0] PeriodReset = 30'd16666667;
  localparam logic [PtsBits-1:0]    PtsMax      = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic OpFrame = 1'b0;
  localparam logic OpTick  = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [TimeBits-1:0]   time_ns;
    logic [31:0]           frame_handle;
    logic signed [PtsBits-1:0] frame_pts;
    logic                  frame_ok;
    logic [TbBits-1:0]     tb_num;
    logic [TbBits-1:0]     tb_den;
  } ifr_in_t;

  typedef struct packed {
    logic [31:0]           out_handle;
    logic signed [PtsBits-1:0] out_pts;
    logic [TbBits-1:0]     out_tb_num;
    logic [TbBits-1:0]     out_tb_den;
    logic                  is_repeat;
  } ifr_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic decide;
    logic mul_divisor;
    logic mul_lo;
    logic mul_hi;
    logic accum;
    logic div_init;
    logic div_step;
    logic emit;
  } ifr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic due;
    logic sat;
    logic div_last;
    logic out_free;
  } ifr_status_t;

  // Keeps the low HandleBits bits of an incoming handle.
  function automatic logic [HandleBits-1:0] handle_keep(logic [31:0] h);
    logic [63:0] w;
    w = 64'(h);
    return w[HandleBits-1:0];
  endfunction

  // Shows the low 32 bits of a stored handle.
  function automatic logic [31:0] handle_show(logic [HandleBits-1:0] h);
    logic [63:0] w;
    w = 64'(h);
    return w[31:0];
  endfunction

endpackage

// File: hw/rtl/ifr_controller.sv
module ifr_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ifr_pkg::ifr_status_t status,
  output ifr_pkg::ifr_cmd_t    cmd
);
  import ifr_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DECIDE   = 9'b000000010,
    ST_DIVISOR  = 9'b000000100,
    ST_PROD_LO  = 9'b000001000,
    ST_PROD_HI  = 9'b000010000,
    ST_ACCUM    = 9'b000100000,
    ST_CHECK    = 9'b001000000,
    ST_DIVIDE   = 9'b010000000,
    ST_EMIT     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (!status.is_tick) begin
          state_next = ST_EMIT;
        end else if (status.due) begin
          state_next = ST_DIVISOR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVISOR: begin
        cmd.mul_divisor = 1'b1;
        state_next      = ST_PROD_LO;
      end
      ST_PROD_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_PROD_HI;
      end
      ST_PROD_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.div_init = 1'b1;
        state_next   = status.sat ? ST_EMIT : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/ifr_datapath.sv
module ifr_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  ifr_pkg::ifr_in_t              in_item,
  input  logic                          cfg_write_en,
  input  logic [ifr_pkg::PeriodBits-1:0] cfg_write_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ifr_pkg::ifr_out_t             out_item,
  input  ifr_pkg::ifr_cmd_t             cmd,
  output ifr_pkg::ifr_status_t          status
);
  import ifr_pkg::*;

  ifr_in_t               item;
  logic [PeriodBits-1:0] period;
  logic                  have_frame;
  logic [63:0]           deadline;
  logic [HandleBits-1:0] stored_handle;
  logic [TbBits-1:0]     stored_tb_num;
  logic [TbBits-1:0]     stored_tb_den;

  logic [63:0]           prod;
  logic [DivBits-1:0]    divisor;
  logic [AccBits-1:0]    acc;
  logic [DivBits-1:0]    rem;
  logic [QuotBits-1:0]   quot;
  logic [CntBits-1:0]    count;
  logic                  sat;

  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           now;
  logic [63:0]           advanced;
  logic [DivBits-1:0]    acc_top;
  logic                  overflow;
  logic [DivBits:0]      trial;
  logic                  trial_ge;

  assign now      = 64'(item.time_ns);
  assign advanced = deadline + 64'(period);
  assign acc_top  = DivBits'(acc[AccBits-1:QuotBits]);
  assign overflow = acc_top >= divisor;
  assign trial    = {rem, quot[QuotBits-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  assign status.is_tick  = item.operation == OpTick;
  assign status.due      = have_frame && (now >= deadline);
  assign status.sat      = overflow;
  assign status.div_last = count == CntBits'(QuotBits - 1);
  assign status.out_free = !out_valid || out_ready;

  // One shared multiplier: the divisor first, then the two halves of time * den.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_divisor) begin
      mul_a = 32'(stored_tb_num);
      mul_b = 32'(NsPerS);
    end else if (cmd.mul_lo) begin
      mul_a = item.time_ns[31:0];
      mul_b = 32'(stored_tb_den);
    end else if (cmd.mul_hi) begin
      mul_a = 32'(item.time_ns[TimeBits-1:32]);
      mul_b = 32'(stored_tb_den);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_item;
    end
    prod <= mul_a * mul_b;
    if (cmd.mul_lo) begin
      divisor <= DivBits'(prod);
    end
    if (cmd.mul_hi) begin
      acc <= AccBits'(prod) + AccBits'(divisor >> 1);
    end
    if (cmd.accum) begin
      acc <= acc + AccBits'({prod, 32'd0});
    end
    if (cmd.div_init) begin
      rem   <= acc_top;
      quot  <= acc[QuotBits-1:0];
      count <= '0;
      sat   <= overflow;
    end
    if (cmd.div_step) begin
      rem   <= trial_ge ? DivBits'(trial - {1'b0, divisor}) : DivBits'(trial);
      quot  <= {quot[QuotBits-2:0], trial_ge};
      count <= count + 1'b1;
    end
    if (cmd.decide && !status.is_tick && item.frame_ok) begin
      stored_handle <= handle_keep(item.frame_handle);
      stored_tb_num <= item.tb_num;
      stored_tb_den <= item.tb_den;
    end
    if (cmd.emit) begin
      if (status.is_tick) begin
        out_item.out_handle <= handle_show(stored_handle);
        out_item.out_pts    <= sat ? PtsMax : 64'(quot);
        out_item.out_tb_num <= stored_tb_num;
        out_item.out_tb_den <= stored_tb_den;
        out_item.is_repeat  <= 1'b1;
      end else begin
        out_item.out_handle <= item.frame_handle;
        out_item.out_pts    <= item.frame_pts;
        out_item.out_tb_num <= item.tb_num;
        out_item.out_tb_den <= item.tb_den;
        out_item.is_repeat  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= PeriodReset;
      have_frame <= 1'b0;
      deadline   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        period <= cfg_write_data;
      end
      if (cmd.decide && !status.is_tick && item.frame_ok) begin
        have_frame <= 1'b1;
        deadline   <= now + 64'(period) + 64'(period >> 1);
      end
      if (cmd.decide && status.is_tick && status.due) begin
        deadline <= (advanced < now) ? now + 64'(period) : advanced;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/idle_frame_repeater.sv
// Channel   Direction  Handshake               Payload
// in        request    in_valid / in_ready     in_item (ifr_in_t)
// out       result     out_valid / out_ready   out_item (ifr_out_t)
// cfg       write      cfg_write_en            cfg_write_data (period_ns)
//
// A request is taken in the idle state and decided in the next cycle; a tick with nothing
// due ends there and a frame goes on to emit. A repeat runs through the shared multiplier
// (four steps: divisor, low and high product, accumulate) and the restoring divider that
// finds one quotient bit per cycle over 63 bits; an overflowing rescale skips the divider.
// Reset is synchronous and active high; it restores the period and forgets the frame.
// A result waits in the output register while out_ready is low, and the next request
// is taken meanwhile; only its own result waits for the register to free up.
module idle_frame_repeater (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ifr_pkg::ifr_in_t               in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ifr_pkg::ifr_out_t              out_item,
  input  logic                           cfg_write_en,
  input  logic [ifr_pkg::PeriodBits-1:0] cfg_write_data
);
  import ifr_pkg::*;

  // The controller sequences each request; the datapath holds the state and math.
  ifr_cmd_t    cmd;
  ifr_status_t status;

  ifr_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath forwards live frames, remembers good ones, tracks the repeat
  // deadline and rescales the current time into the stored frame's time base.
  ifr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .in_item        (in_item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .cmd            (cmd),
    .status         (status)
  );

endmodule
